// File: hw/rtl/can_frame_serial_deframer_assert.svh
// Assertion macros shared by the deframer checker.
`ifndef CAN_FRAME_SERIAL_DEFRAMER_ASSERT_SVH
`define CAN_FRAME_SERIAL_DEFRAMER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define CFD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define CFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

// Same-cycle implication that also holds across reset.
`define CFD_ASSERT_ALWAYS(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) \
        (ante) |-> (cons)) else $error(msg);

`endif

// File: hw/rtl/cfd_pkg.sv
// Types and constants of the CAN frame serial deframer.
package cfd_pkg;

    localparam logic [7:0] BYTE_START = 8'hFD;
    localparam logic [7:0] BYTE_END   = 8'hBF;

    // bytes carried in one result beat
    localparam int unsigned OUT_BYTES = 8;
    localparam int unsigned ID_W      = 12;
    localparam int unsigned LEN_W     = 4;
    localparam int unsigned OUT_W     = ID_W + LEN_W + 8 * OUT_BYTES;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_HEADER = 3'd1,
        PH_IDLOW  = 3'd2,
        PH_DATA   = 3'd3,
        PH_END    = 3'd4
    } t_phase;

endpackage

// File: hw/rtl/can_frame_serial_deframer.sv
// Top level: serial byte stream to CAN-style frame deframer.
// A byte beat lands in the input register and is parsed from there; the result beat
//   for a good end byte is registered in the output register that drives o_m_tvalid.
// Throughput: one byte per cycle; the parser stalls only while a finished result
//   waits in the output register and the staged byte is a good end byte.
// Reset (i_rst_n low, synchronous): parser hunts for the start byte, counters,
//   held ID/length and payload bytes clear, both registers empty.
module can_frame_serial_deframer #(
    parameter int unsigned MAX_PAYLOAD = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    input  logic [7:0]                i_s_tdata,   // [7:0] rx_byte
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    // [11:0] frame_id, [15:12] data_length, [23:16] data_0 .. [79:72] data_7
    output logic [cfd_pkg::OUT_W-1:0] o_m_tdata
);
    import cfd_pkg::*;

    // input register
    logic                 r_in_valid;
    logic [7:0]           r_in_byte;

    // parser state
    t_phase               r_phase, n_phase;
    logic [LEN_W-1:0]     r_left,  n_left;
    logic [ID_W-1:0]      r_id,    n_id;
    logic [LEN_W-1:0]     r_len,   n_len;
    logic [7:0]           r_store [MAX_PAYLOAD];

    // output register
    logic                 r_out_valid;
    logic [OUT_W-1:0]     r_out_data;

    // control from the parser decode
    logic                 n_clear;    // header accepted: wipe payload
    logic                 n_wr;       // data byte to store
    logic                 n_emit;     // good end byte: result beat
    logic                 w_proceed;  // staged byte is consumed this cycle
    logic [LEN_W-1:0]     w_idx;      // payload slot of a data byte
    logic [7:0]           w_data [OUT_BYTES];
    logic [OUT_W-1:0]     w_frame;

    // A staged byte waits only if it would emit while the last result is still held and i_m_tready is low.
    assign w_proceed  = r_in_valid && (!n_emit || !r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_proceed;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    assign w_idx = r_len - r_left;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
    end

    // Parser next state: one byte per step.
    always_comb begin
        n_phase = r_phase;
        n_left  = r_left;
        n_id    = r_id;
        n_len   = r_len;
        n_clear = 1'b0;
        n_wr    = 1'b0;
        n_emit  = 1'b0;
        case (r_phase)
            PH_HEADER: begin
                if (r_in_byte[7:4] > LEN_W'(MAX_PAYLOAD)) begin
                    // oversize length: drop and hunt again, byte not rescanned
                    n_phase = PH_HUNT;
                end else begin
                    n_len   = r_in_byte[7:4];
                    n_id    = {r_in_byte[3:0], 8'h00};
                    n_clear = 1'b1;
                    n_phase = PH_IDLOW;
                end
            end
            PH_IDLOW: begin
                n_id    = r_id | {4'h0, r_in_byte};
                n_left  = r_len;
                n_phase = (r_len == '0) ? PH_END : PH_DATA;
            end
            PH_DATA: begin
                n_wr   = 1'b1;
                n_left = (r_left != '0) ? (r_left - 1'b1) : '0;
                if (n_left == '0) begin
                    n_phase = PH_END;
                end
            end
            PH_END: begin
                // wrong end byte drops the frame silently
                n_phase = PH_HUNT;
                n_emit  = (r_in_byte == BYTE_END);
            end
            default: begin
                n_phase = (r_in_byte == BYTE_START) ? PH_HEADER : PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_left  <= '0;
            r_id    <= '0;
            r_len   <= '0;
        end else if (w_proceed) begin
            r_phase <= n_phase;
            r_left  <= n_left;
            r_id    <= n_id;
            r_len   <= n_len;
        end
    end

    // Payload store: cleared on reset and on an accepted header.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < int'(MAX_PAYLOAD); k++) begin
                r_store[k] <= 8'h00;
            end
        end else if (w_proceed) begin
            for (int k = 0; k < int'(MAX_PAYLOAD); k++) begin
                if (n_clear) begin
                    r_store[k] <= 8'h00;
                end else if (n_wr && (w_idx == LEN_W'(k))) begin
                    r_store[k] <= r_in_byte;
                end
            end
        end
    end

    // Result bytes: slots at or past the length, or past the store, read zero.
    for (genvar g = 0; g < int'(OUT_BYTES); g++) begin : g_out
        if (g < int'(MAX_PAYLOAD)) begin : g_stored
            assign w_data[g] = (LEN_W'(g) < r_len) ? r_store[g] : 8'h00;
        end else begin : g_none
            assign w_data[g] = 8'h00;
        end
        assign w_frame[ID_W+LEN_W+8*g +: 8] = w_data[g];
    end
    assign w_frame[ID_W-1:0]         = r_id;
    assign w_frame[ID_W+LEN_W-1:ID_W] = r_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_proceed && n_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proceed && n_emit) begin
            r_out_data <= w_frame;
        end
    end

endmodule

// File: hw/rtl/cfd_checker.sv
// Port-level checker for the deframer, with its bind.
`include "can_frame_serial_deframer_assert.svh"

module cfd_checker #(
    parameter int unsigned MAX_PAYLOAD = 8
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_m_tvalid,
    input logic                      i_m_tready,
    input logic [cfd_pkg::OUT_W-1:0] o_m_tdata
);
    import cfd_pkg::*;

    logic [LEN_W-1:0] w_len;
    assign w_len = o_m_tdata[ID_W+LEN_W-1:ID_W];

    `CFD_ASSERT_ALWAYS(a_rst_empty, $past(!i_rst_n), !o_m_tvalid, "result beat right after reset")

    `CFD_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata), "stalled result beat changed")

    `CFD_ASSERT_NOW(a_len_max, o_m_tvalid, w_len <= LEN_W'(MAX_PAYLOAD), "length above payload limit")

    for (genvar g = 0; g < int'(OUT_BYTES); g++) begin : g_zero
        `CFD_ASSERT_NOW(a_pad_zero, o_m_tvalid && (w_len <= LEN_W'(g)), o_m_tdata[ID_W+LEN_W+8*g +: 8] == 8'h00, "unused data byte not zero")
    end

endmodule

bind can_frame_serial_deframer cfd_checker #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_cfd_checker (.*);
